@@ sv/taylor_exp_approximation_top_assert.svh @@
// Assertion macros for the taylor_exp_approximation checker.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef TAYLOR_EXP_APPROXIMATION_TOP_ASSERT_SVH
`define TAYLOR_EXP_APPROXIMATION_TOP_ASSERT_SVH

// same-cycle implication
`define TEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("taylor_exp: same-cycle check failed");

// next-cycle implication
`define TEA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("taylor_exp: next-cycle check failed");

`endif

@@ sv/tea_pkg.sv @@
// Shared constants, types and microcode for the Taylor exponential block.
// No dependencies; used by tea_mul and taylor_exp_approximation_top.
package tea_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int RECIP_BITS      = 60;
  localparam int SCALE_BITS      = 40;
  localparam int MAX_ORDER_LIMIT = 12;
  localparam int MAG_W           = 62;   // magnitudes saturate at 2^62 - 1
  localparam int ACC_W           = 128;  // full product width
  localparam int PC_W            = 3;

  localparam logic [MAG_W-1:0] MAG_CAP     = '1;
  localparam logic [3:0]       ORDER_LIMIT = 4'(MAX_ORDER_LIMIT);
  localparam logic [3:0]       ORDER_RESET = 4'd4;
  localparam logic [1:0]       ADDR_SERIES_ORDER = 2'd0;

  localparam logic [63:0] ONE_Q60 = 64'd1 << RECIP_BITS;

  // floor(2^60 / k!) for k = 0..20
  localparam logic [63:0] RECIP_Q60 [21] = '{
    ONE_Q60 / 64'd1,
    ONE_Q60 / 64'd1,
    ONE_Q60 / 64'd2,
    ONE_Q60 / 64'd6,
    ONE_Q60 / 64'd24,
    ONE_Q60 / 64'd120,
    ONE_Q60 / 64'd720,
    ONE_Q60 / 64'd5040,
    ONE_Q60 / 64'd40320,
    ONE_Q60 / 64'd362880,
    ONE_Q60 / 64'd3628800,
    ONE_Q60 / 64'd39916800,
    ONE_Q60 / 64'd479001600,
    ONE_Q60 / 64'd6227020800,
    ONE_Q60 / 64'd87178291200,
    ONE_Q60 / 64'd1307674368000,
    ONE_Q60 / 64'd20922789888000,
    ONE_Q60 / 64'd355687428096000,
    ONE_Q60 / 64'd6402373705728000,
    ONE_Q60 / 64'd121645100408832000,
    ONE_Q60 / 64'd2432902008176640000
  };

  localparam logic [63:0] EVEN_SUM =
    RECIP_Q60[0] + RECIP_Q60[2] + RECIP_Q60[4] + RECIP_Q60[6] + RECIP_Q60[8] +
    RECIP_Q60[10] + RECIP_Q60[12] + RECIP_Q60[14] + RECIP_Q60[16] +
    RECIP_Q60[18] + RECIP_Q60[20];
  localparam logic [63:0] ODD_SUM =
    RECIP_Q60[1] + RECIP_Q60[3] + RECIP_Q60[5] + RECIP_Q60[7] + RECIP_Q60[9] +
    RECIP_Q60[11] + RECIP_Q60[13] + RECIP_Q60[15] + RECIP_Q60[17] +
    RECIP_Q60[19];
  localparam logic [63:0] E_Q60    = EVEN_SUM + ODD_SUM;
  localparam logic [63:0] EINV_Q60 = EVEN_SUM - ODD_SUM;

  // post-multiply right shift
  typedef enum logic [1:0] {
    SHR_FRAC,
    SHR_RECIP,
    SHR_SCALE
  } shr_sel_t;

  typedef struct packed {
    logic     go;
    shr_sel_t shr;
  } mul_req_t;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_MUL_POW,
    OP_MUL_TERM,
    OP_NOP,
    OP_MUL_SCALE,
    OP_MUL_FINAL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_ORDER_ZERO,
    C_N_LE_ORDER,
    C_CNT_ZERO
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  localparam logic [PC_W-1:0] PC_POW       = 3'd1;
  localparam logic [PC_W-1:0] PC_SCALE_CHK = 3'd4;
  localparam logic [PC_W-1:0] PC_FINAL     = 3'd6;

  // control store
  function automatic ucw_t ucode_rom(logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      3'd0:    w = '{op: OP_INIT,      cond: C_ORDER_ZERO, target: PC_SCALE_CHK};
      3'd1:    w = '{op: OP_MUL_POW,   cond: C_NEXT,       target: '0};
      3'd2:    w = '{op: OP_MUL_TERM,  cond: C_NEXT,       target: '0};
      3'd3:    w = '{op: OP_NOP,       cond: C_N_LE_ORDER, target: PC_POW};
      3'd4:    w = '{op: OP_NOP,       cond: C_CNT_ZERO,   target: PC_FINAL};
      3'd5:    w = '{op: OP_MUL_SCALE, cond: C_ALWAYS,     target: PC_SCALE_CHK};
      3'd6:    w = '{op: OP_MUL_FINAL, cond: C_NEXT,       target: '0};
      default: w = '{op: OP_EMIT,      cond: C_NEXT,       target: '0};
    endcase
    return w;
  endfunction

  // floor(2^60 / n!) for the term multiply
  function automatic logic [MAG_W-1:0] term_recip(logic [3:0] n);
    logic [MAG_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_Q60[1][MAG_W-1:0];
      4'd2:    r = RECIP_Q60[2][MAG_W-1:0];
      4'd3:    r = RECIP_Q60[3][MAG_W-1:0];
      4'd4:    r = RECIP_Q60[4][MAG_W-1:0];
      4'd5:    r = RECIP_Q60[5][MAG_W-1:0];
      4'd6:    r = RECIP_Q60[6][MAG_W-1:0];
      4'd7:    r = RECIP_Q60[7][MAG_W-1:0];
      4'd8:    r = RECIP_Q60[8][MAG_W-1:0];
      4'd9:    r = RECIP_Q60[9][MAG_W-1:0];
      4'd10:   r = RECIP_Q60[10][MAG_W-1:0];
      4'd11:   r = RECIP_Q60[11][MAG_W-1:0];
      4'd12:   r = RECIP_Q60[12][MAG_W-1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/taylor_exp_approximation_top.sv @@
// Taylor-series e^x about an integer point, microcoded sequencer over one multiplier.
// Depends on tea_pkg and tea_mul.
//
//   channel  | dir | signals                                 | beat taken when
//   ---------+-----+-----------------------------------------+---------------------------
//   command  | in  | start, busy, arg_value, center_point    | start && !busy
//   result   | out | done, exp_value, saturated              | done (one cycle, no stall)
//   config   | in  | psel, penable, pwrite, paddr, pwdata,   | psel && penable && pwrite
//            |     | prdata, pready                          |   && pready
//
// Each multiply step runs in the shared 32x32 multiplier as four partial products,
// a drain and a shift.
// busy drops in the cycle that done is shown, so the next command can be taken then.
// rst is synchronous: it idles the sequencer and sets series_order to 4.
// The result beat cannot be held off; it is shown for exactly one cycle.
module taylor_exp_approximation_top (
  input  logic               clk,
  input  logic               rst,
  // command
  input  logic               start,
  output logic               busy,
  input  logic signed [21:0] arg_value,
  input  logic signed [4:0]  center_point,
  // result
  output logic               done,
  output logic [31:0]        exp_value,
  output logic               saturated,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- config register ----------------
  logic [3:0] series_order;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == tea_pkg::ADDR_SERIES_ORDER);
  assign prdata = (paddr == tea_pkg::ADDR_SERIES_ORDER) ? 32'(series_order) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_order <= tea_pkg::ORDER_RESET;
    end else if (cfg_wr) begin
      series_order <= pwdata[3:0];
    end
  end

  // ---------------- command decode ----------------
  logic               accept;
  logic signed [22:0] x_ext;
  logic signed [22:0] a_fix;
  logic signed [22:0] d_full;
  logic [22:0]        d_negd;

  assign accept = start && !busy;
  assign x_ext  = 23'(arg_value);
  assign a_fix  = 23'(center_point) <<< tea_pkg::FRAC_BITS;
  assign d_full = x_ext - a_fix;   // shift x - a in Q.16, always fits 23 bits
  assign d_negd = -d_full;

  // ---------------- datapath registers ----------------
  logic [21:0]                dmag;       // |x - a|
  logic                       dneg;       // x - a < 0: odd terms subtract
  logic                       a_neg;      // scale by 1/e instead of e
  logic [4:0]                 cnt;        // scale multiplies left
  logic [3:0]                 order;
  logic [3:0]                 n;          // current term order
  logic [tea_pkg::MAG_W-1:0]  pw;         // running power, Q.16
  logic signed [63:0]         sum;        // partial sum, Q.16, clamped to +-cap
  logic [tea_pkg::MAG_W-1:0]  scale;      // e^a, Q.40
  logic [tea_pkg::MAG_W-1:0]  prod;       // |sum| * scale, Q.16

  // ---------------- sequencer ----------------
  logic [tea_pkg::PC_W-1:0]  pc;
  logic                      mul_wait;
  tea_pkg::ucw_t             ucw;
  logic                      is_mul;
  logic                      step_done;
  logic                      take;

  tea_pkg::mul_req_t         mreq;
  logic [tea_pkg::MAG_W-1:0] mopa;
  logic [tea_pkg::MAG_W-1:0] mopb;
  logic                      mdone;
  logic [tea_pkg::MAG_W-1:0] mres;

  logic [tea_pkg::MAG_W-1:0] factor;
  logic [tea_pkg::MAG_W-1:0] smag;
  logic signed [63:0]        term_s;
  logic signed [63:0]        sum_raw;
  logic signed [63:0]        sum_next;
  logic signed [63:0]        cap_s;
  logic signed [63:0]        sum_negd;

  assign ucw = tea_pkg::ucode_rom(pc);

  assign is_mul = (ucw.op == tea_pkg::OP_MUL_POW) || (ucw.op == tea_pkg::OP_MUL_TERM) ||
                  (ucw.op == tea_pkg::OP_MUL_SCALE) || (ucw.op == tea_pkg::OP_MUL_FINAL);
  assign step_done = busy && (!is_mul || (mul_wait && mdone));

  always_comb begin
    case (ucw.cond)
      tea_pkg::C_NEXT:       take = 1'b0;
      tea_pkg::C_ALWAYS:     take = 1'b1;
      tea_pkg::C_ORDER_ZERO: take = (order == 4'd0);
      tea_pkg::C_N_LE_ORDER: take = (n <= order);
      tea_pkg::C_CNT_ZERO:   take = (cnt == 5'd0);
      default:               take = 1'b0;
    endcase
  end

  assign factor   = a_neg ? tea_pkg::EINV_Q60[tea_pkg::MAG_W-1:0]
                          : tea_pkg::E_Q60[tea_pkg::MAG_W-1:0];
  assign sum_negd = -sum;
  assign smag     = sum[63] ? sum_negd[tea_pkg::MAG_W-1:0] : sum[tea_pkg::MAG_W-1:0];

  // operand routing for the shared multiplier
  always_comb begin
    mreq.go  = busy && is_mul && !mul_wait;
    mreq.shr = tea_pkg::SHR_RECIP;
    mopa     = '0;
    mopb     = '0;
    case (ucw.op)
      tea_pkg::OP_MUL_POW: begin
        mreq.shr = tea_pkg::SHR_FRAC;
        mopa     = pw;
        mopb     = tea_pkg::MAG_W'(dmag);
      end
      tea_pkg::OP_MUL_TERM: begin
        mreq.shr = tea_pkg::SHR_RECIP;
        mopa     = pw;
        mopb     = tea_pkg::term_recip(n);
      end
      tea_pkg::OP_MUL_SCALE: begin
        mreq.shr = tea_pkg::SHR_RECIP;
        mopa     = scale;
        mopb     = factor;
      end
      tea_pkg::OP_MUL_FINAL: begin
        mreq.shr = tea_pkg::SHR_SCALE;
        mopa     = smag;
        mopb     = scale;
      end
      default: begin
        mreq.shr = tea_pkg::SHR_RECIP;
      end
    endcase
  end

  tea_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .opa  (mopa),
    .opb  (mopb),
    .done (mdone),
    .res  (mres)
  );

  // term accumulate with clamp to +-(2^62 - 1)
  assign cap_s   = signed'(64'(tea_pkg::MAG_CAP));
  assign term_s  = signed'(64'(mres));
  assign sum_raw = (dneg && n[0]) ? (sum - term_s) : (sum + term_s);

  always_comb begin
    if (sum_raw > cap_s) begin
      sum_next = cap_s;
    end else if (sum_raw < -cap_s) begin
      sum_next = -cap_s;
    end else begin
      sum_next = sum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      mul_wait <= 1'b0;
      pc       <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy     <= 1'b1;
        pc       <= '0;
        mul_wait <= 1'b0;
        dmag     <= d_full[22] ? d_negd[21:0] : d_full[21:0];
        dneg     <= d_full[22];
        a_neg    <= center_point[4];
        cnt      <= center_point[4] ? 5'(-center_point) : 5'(center_point);
        order    <= (series_order > tea_pkg::ORDER_LIMIT) ? tea_pkg::ORDER_LIMIT
                                                          : series_order;
      end else if (busy) begin
        if (mreq.go) begin
          mul_wait <= 1'b1;
        end
        if (step_done) begin
          mul_wait <= 1'b0;
          pc       <= take ? ucw.target : pc + 3'd1;
          case (ucw.op)
            tea_pkg::OP_INIT: begin
              pw    <= tea_pkg::MAG_W'(1) << tea_pkg::FRAC_BITS;
              sum   <= 64'sd1 <<< tea_pkg::FRAC_BITS;
              scale <= tea_pkg::MAG_W'(1) << tea_pkg::SCALE_BITS;
              n     <= 4'd1;
            end
            tea_pkg::OP_MUL_POW: begin
              pw <= mres;
            end
            tea_pkg::OP_MUL_TERM: begin
              sum <= sum_next;
              n   <= n + 4'd1;
            end
            tea_pkg::OP_MUL_SCALE: begin
              scale <= mres;
              cnt   <= cnt - 5'd1;
            end
            tea_pkg::OP_MUL_FINAL: begin
              prod <= mres;
            end
            tea_pkg::OP_EMIT: begin
              busy <= 1'b0;
              done <= 1'b1;
              // negative sum clips to zero; a zero product is a plain zero
              if (sum[63] && (prod != '0)) begin
                exp_value <= '0;
                saturated <= 1'b1;
              end else if (|prod[tea_pkg::MAG_W-1:32]) begin
                exp_value <= '1;
                saturated <= 1'b1;
              end else begin
                exp_value <= prod[31:0];
                saturated <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

endmodule

@@ sv/tea_mul.sv @@
// Multi-cycle 62x62 multiply, right shift and saturate at 2^62 - 1.
// Depends on tea_pkg. Four 32x32 partial products, one per cycle, then a drain.
module tea_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  tea_pkg::mul_req_t        req,
  input  logic [tea_pkg::MAG_W-1:0] opa,
  input  logic [tea_pkg::MAG_W-1:0] opb,
  output logic                     done,
  output logic [tea_pkg::MAG_W-1:0] res
);

  logic [tea_pkg::MAG_W-1:0] a_q;
  logic [tea_pkg::MAG_W-1:0] b_q;
  tea_pkg::shr_sel_t         shr_q;
  logic                      run;
  logic [2:0]                step;
  logic [63:0]               pp;
  logic [1:0]                pp_off;
  logic                      pp_vld;
  logic [tea_pkg::ACC_W-1:0] acc;

  logic [31:0]               a_half;
  logic [31:0]               b_half;
  logic [tea_pkg::ACC_W-1:0] pp_shifted;
  logic [tea_pkg::ACC_W-1:0] acc_sh;
  logic                      sat;

  assign a_half = step[1] ? 32'(a_q[tea_pkg::MAG_W-1:32]) : a_q[31:0];
  assign b_half = step[0] ? 32'(b_q[tea_pkg::MAG_W-1:32]) : b_q[31:0];
  assign pp_shifted = tea_pkg::ACC_W'(pp) << (7'd32 * 7'(pp_off));

  always_comb begin
    case (shr_q)
      tea_pkg::SHR_FRAC:  acc_sh = acc >> tea_pkg::FRAC_BITS;
      tea_pkg::SHR_RECIP: acc_sh = acc >> tea_pkg::RECIP_BITS;
      tea_pkg::SHR_SCALE: acc_sh = acc >> tea_pkg::SCALE_BITS;
      default:            acc_sh = acc;
    endcase
  end

  assign sat = |acc_sh[tea_pkg::ACC_W-1:tea_pkg::MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        a_q    <= opa;
        b_q    <= opb;
        shr_q  <= req.shr;
        acc    <= '0;
        step   <= '0;
        run    <= 1'b1;
        pp_vld <= 1'b0;
      end else if (run) begin
        if (pp_vld) begin
          acc <= acc + pp_shifted;
        end
        if (!step[2]) begin
          pp     <= 64'(a_half) * 64'(b_half);
          pp_off <= 2'(step[1]) + 2'(step[0]);
          pp_vld <= 1'b1;
          step   <= step + 3'd1;
        end else if (pp_vld) begin
          pp_vld <= 1'b0;
          step   <= step + 3'd1;
        end else begin
          res  <= sat ? tea_pkg::MAG_CAP : acc_sh[tea_pkg::MAG_W-1:0];
          done <= 1'b1;
          run  <= 1'b0;
        end
      end
    end
  end

endmodule

@@ sv/tea_checker.sv @@
// Port-level checker for taylor_exp_approximation_top, bound to the top level.
// Depends on taylor_exp_approximation_top_assert.svh.
`include "taylor_exp_approximation_top_assert.svh"

module tea_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] exp_value,
  input logic        saturated
);

  `TEA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `TEA_ASSERT_IMP(a_done_idle, done, !busy)
  `TEA_ASSERT_NXT(a_done_single, done, !done)
  `TEA_ASSERT_IMP(a_sat_clip, done && saturated, (exp_value == 32'd0) || (exp_value == 32'hFFFFFFFF))

endmodule

bind taylor_exp_approximation_top tea_checker u_tea_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for taylor_exp_approximation_top: e^x about an integer point.
// Depends on tea_pkg (register address) and the RTL under sv/; predicts every
// result in-line and checks it against the DUT's result beats.
`timescale 1ns / 100ps

module testbench;

  // fixed-point formats of the datapath
  localparam int          FRAC_W    = 16;
  localparam int          RECIP_W   = 60;
  localparam int          SCALE_W   = 40;
  localparam int          ORDER_MAX = 12;
  localparam logic [63:0] MAG_LIMIT = (64'd1 << 62) - 64'd1;
  localparam logic [31:0] EXP_MAX   = 32'hFFFF_FFFF;

  // watchdog limit, well above the worst beat-to-beat gap with its random hold-off
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 170;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } exp_beat_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [21:0] arg_value;
  logic signed [4:0]  center_point;
  logic               done;
  logic [31:0]        exp_value;
  logic               saturated;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  exp_beat_t   exp_pending [$];   // predicted results, oldest first
  logic [3:0]  series_order_q;    // our copy of the order register
  logic [63:0] e_q60;             // e in Q.60
  logic [63:0] e_inv_q60;         // 1/e in Q.60
  int          mismatch_count = 0;
  int          idle_cycles    = 0;

  taylor_exp_approximation_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .arg_value    (arg_value),
    .center_point (center_point),
    .done         (done),
    .exp_value    (exp_value),
    .saturated    (saturated),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor(a * b / 2^sh), clipped to the 62-bit magnitude ceiling
  function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > {64'd0, MAG_LIMIT}) ? MAG_LIMIT : p[63:0];
  endfunction

  // e or 1/e as the truncated series sum of +-floor(2^60 / k!), k = 0..20
  function automatic logic [63:0] euler_q60(bit inverse);
    logic [63:0] fact;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    fact = 64'd1;
    pos  = 64'd0;
    neg  = 64'd0;
    for (int k = 0; k <= 20; k++) begin
      if (k > 0) fact = fact * 64'(k);
      t = (64'd1 << RECIP_W) / fact;
      if (inverse && (k % 2 == 1)) neg += t;
      else pos += t;
    end
    return pos - neg;
  endfunction

  // expected result for one command beat under the current order register
  function automatic exp_beat_t predict_exp(logic signed [21:0] x, logic signed [4:0] a);
    longint      shift;
    longint      acc;
    logic [63:0] shift_mag;
    logic [63:0] pw;
    logic [63:0] fact;
    logic [63:0] term;
    logic [63:0] scale;
    logic [63:0] prod;
    int          terms;
    int          steps;
    exp_beat_t   r;
    shift     = longint'(x) - longint'(a) * (longint'(1) << FRAC_W);
    shift_mag = (shift < 0) ? 64'(-shift) : 64'(shift);
    terms     = (series_order_q > ORDER_MAX) ? ORDER_MAX : int'(series_order_q);
    pw        = 64'd1 << FRAC_W;
    fact      = 64'd1;
    acc       = longint'(pw);
    for (int n = 1; n <= terms; n++) begin
      pw   = mul_q(pw, shift_mag, FRAC_W);
      fact = fact * 64'(n);
      term = mul_q(pw, (64'd1 << RECIP_W) / fact, RECIP_W);
      // odd powers of a negative shift subtract
      if (shift < 0 && (n % 2 == 1)) acc -= longint'(term);
      else acc += longint'(term);
      if (acc > longint'(MAG_LIMIT)) acc = longint'(MAG_LIMIT);
      if (acc < -longint'(MAG_LIMIT)) acc = -longint'(MAG_LIMIT);
    end
    // e^a by repeated multiply, so a negative point never divides
    scale = 64'd1 << SCALE_W;
    steps = (a < 0) ? -int'(a) : int'(a);
    for (int k = 0; k < steps; k++)
      scale = mul_q(scale, (a < 0) ? e_inv_q60 : e_q60, RECIP_W);
    prod = mul_q((acc < 0) ? 64'(-acc) : 64'(acc), scale, SCALE_W);
    // a negative sum clips to zero only if it survives the scale
    if (acc < 0 && prod != 64'd0) begin
      r.value = 32'd0;
      r.sat   = 1'b1;
    end else if (prod > 64'(EXP_MAX)) begin
      r.value = EXP_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = prod[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command, config and drain tasks
  // ---------------------------------------------------------------------------

  // one command beat; start stays high on return so back-to-back beats need no gap
  task automatic send_arg(logic signed [21:0] x, logic signed [4:0] a, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    arg_value    <= x;
    center_point <= a;
    do @(posedge clk); while (busy);
    exp_pending.push_back(predict_exp(x, a));
  endtask

  // hold off commands until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (exp_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access, then idle with psel low so the next transfer
  // never assigns psel in the same step
  task automatic write_series_order(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tea_pkg::ADDR_SERIES_ORDER;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    series_order_q = v[3:0];
    @(posedge clk);
  endtask

  task automatic check_series_order();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= tea_pkg::ADDR_SERIES_ORDER;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(series_order_q)) begin
      $error("prdata: expected %0h, got %0h", 32'(series_order_q), prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // random write data: the low nibble is the order, upper bits must be dropped
  task automatic set_order(logic [3:0] ord);
    logic [31:0] v;
    v = $urandom();
    v[3:0] = ord;
    write_series_order(v);
    check_series_order();
  endtask

  // half the arguments near the point (meaningful sums), most others full-range, some edges
  task automatic draw_arg(output logic signed [21:0] x, output logic signed [4:0] a);
    int sel;
    sel = $urandom_range(0, 9);
    a   = 5'($urandom());
    if (sel < 4)
      x = 22'($urandom());
    else if (sel < 9)
      x = 22'(int'(a) * 65536 + int'($urandom_range(0, 524288)) - 262144);
    else begin
      case ($urandom_range(0, 4))
        0:       x = -22'sd2097152;
        1:       x = 22'sd2097151;
        2:       x = 22'sd0;
        3:       x = -22'sd1;
        default: x = 22'sd1;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // register comes up at order 4; a few beats at that setting
  task automatic test_reset_value();
    check_series_order();
    send_arg(22'sd0, 5'sd0, 0);
    send_arg(22'sd65536, 5'sd1, $urandom_range(0, 12));
    send_arg(-22'sd65536, -5'sd1, $urandom_range(0, 12));
    drain_results();
  endtask

  task automatic test_directed_cases();
    // full order: extremes, magnitude overflow inside the series, bit patterns
    set_order(4'd12);
    send_arg(22'sd0, 5'sd0, 0);
    send_arg(22'sd2097151, 5'sd15, $urandom_range(0, 12));
    send_arg(-22'sd2097152, -5'sd16, $urandom_range(0, 12));
    send_arg(22'sd2097151, -5'sd16, 0);
    send_arg(-22'sd2097152, 5'sd15, 0);
    send_arg(22'sd32768, 5'sd0, $urandom_range(0, 12));
    send_arg(-22'sd32768, 5'sd0, 0);
    send_arg(22'h2AAAAA, 5'b10101, $urandom_range(0, 12));
    send_arg(22'h155555, 5'b01010, 0);
    drain_results();
    // order 1: negative sum clips to zero, zero sum, negative sum lost in the scale
    set_order(4'd1);
    send_arg(-22'sd2097152, 5'sd15, 0);
    send_arg(-22'sd65536, 5'sd0, $urandom_range(0, 12));
    send_arg(-22'sd1114113, -5'sd16, 0);
    send_arg(22'sd131072, 5'sd0, 0);
    drain_results();
    // order 0: plain e^a, too large at the top of the point range
    set_order(4'd0);
    send_arg(22'sd0, 5'sd15, 0);
    send_arg(22'sd0, 5'sd10, $urandom_range(0, 12));
    send_arg(22'sd123456, -5'sd16, 0);
    send_arg(22'sd0, 5'sd0, 0);
    drain_results();
    // orders above the limit act as the limit
    set_order(4'd15);
    send_arg(22'sd65536, 5'sd1, 0);
    send_arg(22'sd2097151, 5'sd15, $urandom_range(0, 12));
    send_arg(-22'sd2097152, -5'sd16, 0);
    drain_results();
  endtask

  // every register value, read back, a few beats each
  task automatic test_order_sweep();
    logic signed [21:0] x;
    logic signed [4:0]  a;
    for (int v = 0; v < 16; v++) begin
      set_order(4'(v));
      repeat (3) begin
        draw_arg(x, a);
        send_arg(x, a, $urandom_range(0, 12));
      end
      drain_results();
    end
  endtask

  // random beats over several settings; every third phase runs back to back,
  // and each phase pauses mid-way until all results are back
  task automatic test_random_args();
    logic signed [21:0] x;
    logic signed [4:0]  a;
    logic [3:0]         ord;
    bit                 burst;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       ord = 4'd0;
        1:       ord = 4'd12;
        2:       ord = 4'd15;
        default: ord = 4'($urandom_range(0, 15));
      endcase
      set_order(ord);
      burst = (ph % 3 == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        draw_arg(x, a);
        send_arg(x, a, burst ? 0 : $urandom_range(0, 12));
        if (i % 60 == 59) drain_results();
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done is a one-cycle beat that cannot be stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    exp_beat_t want;
    if (!rst && done) begin
      if (exp_pending.size() == 0) begin
        $error("result beat with nothing pending: exp_value %0h saturated %0b",
               exp_value, saturated);
        mismatch_count++;
      end else begin
        want = exp_pending.pop_front();
        if (exp_value !== want.value) begin
          $error("exp_value: expected %0h, got %0h", want.value, exp_value);
          mismatch_count++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any command, result or register beat counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** taylor_exp_approximation_top: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    arg_value    <= '0;
    center_point <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    e_q60          = euler_q60(1'b0);
    e_inv_q60      = euler_q60(1'b1);
    series_order_q = 4'd4;  // reset value of the order register
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_value();
    test_directed_cases();
    test_order_sweep();
    test_random_args();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** taylor_exp_approximation_top: PASSED **");
    else
      $display("** taylor_exp_approximation_top: FAILED **");
    $finish;
  end

endmodule
